FILE: rtl/ttcw_pkg.sv
// Shared types and constants for the text terminal cursor writer.
package ttcw_pkg;

    localparam int SCREEN_WIDTH_DEF  = 80;
    localparam int SCREEN_HEIGHT_DEF = 25;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;
    localparam int CHAR_W = 8;
    localparam int DATA_W = 16;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
    localparam int                TAB_STEP     = 8;

    localparam logic [CHAR_W-1:0] COLOUR_RESET = 8'h07;

    typedef enum logic {
        OP_PUT = 1'b0,
        OP_SET = 1'b1
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  cursor_x;
        logic [ROW_W-1:0]  cursor_y;
    } item_t;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] cell_address;
        logic [DATA_W-1:0] cell_data;
        logic [COL_W-1:0]  column_now;
        logic [ROW_W-1:0]  row_now;
    } result_t;

endpackage

FILE: rtl/text_terminal_cursor_writer_unit.sv
// Top level of the text terminal cursor writer.
//
// Input stream (s_*): one transaction per character or set-cursor request.
// s_tuser[0] selects the request: 0 put character, 1 set cursor.
// Output stream (m_*): exactly one transaction per input transaction, in order:
// an optional cell write (m_tuser[0]) with address row*SCREEN_WIDTH+column and
// data {colour, char}, plus the cursor column and row after the request.
// Config channel (cfg_*): writes the attribute byte used for cell data; it is
// always ready and is to be written only while no request is in flight.
// Path: a request accepted into the input register has its result written to the
// result register, where it is held until it is taken from m_tdata.
// Throughput: one request per cycle while m_tready does not stall the result;
// the cursor update is combinational logic between the input and result registers.
// Reset: cursor goes to row 0, column 0, attribute byte to 0x07, both
// register stages empty.
// Stall: while m_tready is low the result is held, the input register fills,
// then s_tready drops until the result is taken.
module text_terminal_cursor_writer_unit #(
    parameter int SCREEN_WIDTH  = ttcw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ttcw_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], cursor_x[14:8], cursor_y[19:15], zero pad
    input  logic [0:0]  s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // cell_address[10:0], cell_data[26:11],
                                   // column_now[33:27], row_now[38:34], zero pad
    output logic [0:0]  m_tuser,   // write_enable[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // text_colour
);

    logic [ttcw_pkg::CHAR_W-1:0] colour_reg;

    ttcw_pkg::item_t   s_item;
    ttcw_pkg::item_t   held_item;
    ttcw_pkg::result_t step_result;
    ttcw_pkg::result_t out_result;

    logic in_valid;
    logic out_free;
    logic advance;
    logic s_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colour_reg <= ttcw_pkg::COLOUR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            colour_reg <= cfg_data;
        end
    end

    assign s_item.op        = ttcw_pkg::op_t'(s_tuser[0]);
    assign s_item.char_code = s_tdata[7:0];
    assign s_item.cursor_x  = s_tdata[14:8];
    assign s_item.cursor_y  = s_tdata[19:15];

    assign advance  = in_valid && out_free;
    assign s_tready = !in_valid || out_free;
    assign s_load   = s_tvalid && s_tready;

    ttcw_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_load),
        .item_in  (s_item),
        .advance  (advance),
        .valid    (in_valid),
        .item_out (held_item)
    );

    ttcw_cursor #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_cursor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (held_item),
        .colour  (colour_reg),
        .result  (step_result)
    );

    ttcw_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .result_in  (step_result),
        .ready      (m_tready),
        .valid      (m_tvalid),
        .free       (out_free),
        .result_out (out_result)
    );

    assign m_tuser[0] = out_result.write_enable;
    assign m_tdata    = {1'b0, out_result.row_now, out_result.column_now,
                         out_result.cell_data, out_result.cell_address};

endmodule

FILE: rtl/ttcw_in_reg.sv
// Input register stage: holds one accepted item until the cursor logic takes it.
module ttcw_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  ttcw_pkg::item_t item_in,
    input  logic           advance,
    output logic           valid,
    output ttcw_pkg::item_t item_out
);

    logic            valid_reg;
    logic            valid_next;
    ttcw_pkg::item_t item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

FILE: rtl/ttcw_cursor.sv
// Cursor state and the per-item update: cell write decode and new cursor position.
module ttcw_cursor #(
    parameter int SCREEN_WIDTH  = ttcw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ttcw_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  ttcw_pkg::item_t               item,
    input  logic [ttcw_pkg::CHAR_W-1:0]   colour,
    output ttcw_pkg::result_t             result
);

    localparam int COL_W  = ttcw_pkg::COL_W;
    localparam int ROW_W  = ttcw_pkg::ROW_W;
    localparam int PROD_W = COL_W + ROW_W + 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_HEIGHT - 1);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [ROW_W-1:0] row_inc;
    logic [COL_W:0]   tab_col;
    logic             set_ok;
    logic             we;
    logic [COL_W-1:0] wcol;
    logic [ROW_W-1:0] wrow;
    logic [ttcw_pkg::CHAR_W-1:0] wch;
    logic [PROD_W-1:0] addr_full;

    assign row_inc = (row_reg == ROW_LAST) ? '0 : row_reg + 1'b1;
    // advance to the next tab stop after the current column
    assign tab_col = ({1'b0, col_reg} + (COL_W+1)'(ttcw_pkg::TAB_STEP))
                     & ~(COL_W+1)'(ttcw_pkg::TAB_STEP - 1);
    assign set_ok  = ({1'b0, item.cursor_x} < (COL_W+1)'(SCREEN_WIDTH))
                  && ({1'b0, item.cursor_y} < (ROW_W+1)'(SCREEN_HEIGHT));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        we       = 1'b0;
        wch      = item.char_code;
        if (item.op == ttcw_pkg::OP_SET) begin
            if (set_ok) begin
                col_next = item.cursor_x;
                row_next = item.cursor_y;
            end
        end else begin
            case (item.char_code)
                ttcw_pkg::CH_NEWLINE: begin
                    col_next = '0;
                    row_next = row_inc;
                end
                ttcw_pkg::CH_BACKSPACE: begin
                    if (col_reg != '0) begin
                        col_next = col_reg - 1'b1;
                    end else if (row_reg != '0) begin
                        col_next = COL_LAST;
                        row_next = row_reg - 1'b1;
                    end
                    we  = 1'b1;
                    wch = ttcw_pkg::CH_SPACE;
                end
                ttcw_pkg::CH_TAB: begin
                    if (tab_col >= (COL_W+1)'(SCREEN_WIDTH)) begin
                        col_next = '0;
                        row_next = row_inc;
                    end else begin
                        col_next = tab_col[COL_W-1:0];
                    end
                end
                default: begin
                    we = 1'b1;
                    if (col_reg == COL_LAST) begin
                        col_next = '0;
                        row_next = row_inc;
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    // backspace writes at the new cursor, a printable byte at the old one
    assign wcol = (item.char_code == ttcw_pkg::CH_BACKSPACE) ? col_next : col_reg;
    assign wrow = (item.char_code == ttcw_pkg::CH_BACKSPACE) ? row_next : row_reg;
    assign addr_full = PROD_W'(wrow) * PROD_W'(SCREEN_WIDTH) + PROD_W'(wcol);

    always_comb begin
        result.write_enable = we;
        result.cell_address = we ? addr_full[ttcw_pkg::ADDR_W-1:0] : '0;
        result.cell_data    = we ? {colour, wch} : '0;
        result.column_now   = col_next;
        result.row_now      = row_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (advance) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, col_reg} < (COL_W+1)'(SCREEN_WIDTH))
        else $error("cursor column out of range");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, row_reg} < (ROW_W+1)'(SCREEN_HEIGHT))
        else $error("cursor row out of range");

    a_set_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.op == ttcw_pkg::OP_SET |-> !result.write_enable)
        else $error("set-cursor produced a cell write");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(col_reg) && $stable(row_reg))
        else $error("cursor moved without an item");

endmodule

FILE: rtl/ttcw_out_reg.sv
// Result register: holds one result until the downstream side takes it.
module ttcw_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  ttcw_pkg::result_t result_in,
    input  logic              ready,
    output logic              valid,
    output logic              free,
    output ttcw_pkg::result_t result_out
);

    logic              valid_reg;
    logic              valid_next;
    ttcw_pkg::result_t result_reg;

    assign free = !valid_reg || ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

    assign valid      = valid_reg;
    assign result_out = result_reg;

endmodule

FILE: tb/ttcw_result_checker.sv
// Checker for the text terminal cursor writer: tracks the cursor, predicts results, compares.
module ttcw_result_checker #(
    parameter int SCREEN_WIDTH  = ttcw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ttcw_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], cursor_x[14:8], cursor_y[19:15], zero pad
    input  logic [0:0]  s_tuser,   // op[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // cell_address[10:0], cell_data[26:11],
                                   // column_now[33:27], row_now[38:34], zero pad
    input  logic [0:0]  m_tuser,   // write_enable[0]
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,  // text_colour
    output int          mismatch_count,
    output int          in_flight
);
    import ttcw_pkg::*;

    int                cur_col;
    int                cur_row;
    logic [CHAR_W-1:0] colour;
    result_t           expected_cells[$];

    function automatic int next_row(input int row);
        return (row + 1 >= SCREEN_HEIGHT) ? 0 : row + 1;
    endfunction

    // Applies one request to the shadow cursor and returns the result it must produce.
    function automatic result_t advance_cursor(input item_t req);
        result_t           r;
        logic              hit;
        int                wcol;
        int                wrow;
        logic [CHAR_W-1:0] wch;
        r    = '0;
        hit  = 1'b0;
        wcol = 0;
        wrow = 0;
        wch  = '0;
        if (req.op == OP_SET) begin
            if (int'(req.cursor_x) < SCREEN_WIDTH && int'(req.cursor_y) < SCREEN_HEIGHT) begin
                cur_col = int'(req.cursor_x);
                cur_row = int'(req.cursor_y);
            end
        end else if (req.char_code == CH_NEWLINE) begin
            cur_col = 0;
            cur_row = next_row(cur_row);
        end else if (req.char_code == CH_BACKSPACE) begin
            if (cur_col > 0) begin
                cur_col = cur_col - 1;
            end else if (cur_row > 0) begin
                cur_row = cur_row - 1;
                cur_col = SCREEN_WIDTH - 1;
            end
            // top-left corner: cursor stays, cell still blanked
            hit  = 1'b1;
            wcol = cur_col;
            wrow = cur_row;
            wch  = CH_SPACE;
        end else if (req.char_code == CH_TAB) begin
            cur_col = (cur_col / TAB_STEP + 1) * TAB_STEP;
            if (cur_col >= SCREEN_WIDTH) begin
                cur_col = 0;
                cur_row = next_row(cur_row);
            end
        end else begin
            hit     = 1'b1;
            wcol    = cur_col;
            wrow    = cur_row;
            wch     = req.char_code;
            cur_col = cur_col + 1;
            if (cur_col >= SCREEN_WIDTH) begin
                cur_col = 0;
                cur_row = next_row(cur_row);
            end
        end
        if (hit) begin
            r.write_enable = 1'b1;
            r.cell_address = ADDR_W'(wrow * SCREEN_WIDTH + wcol);
            r.cell_data    = {colour, wch};
        end
        r.column_now = COL_W'(cur_col);
        r.row_now    = ROW_W'(cur_row);
        return r;
    endfunction

    task automatic report(input string msg);
        if (mismatch_count < 20) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        mismatch_count = mismatch_count + 1;
    endtask

    always @(posedge aclk) begin : watch
        item_t   req;
        result_t got;
        result_t want;
        if (!aresetn) begin
            cur_col        = 0;
            cur_row        = 0;
            colour         = COLOUR_RESET;
            mismatch_count = 0;
            expected_cells.delete();
            in_flight <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.write_enable = m_tuser[0];
                got.cell_address = m_tdata[10:0];
                got.cell_data    = m_tdata[26:11];
                got.column_now   = m_tdata[33:27];
                got.row_now      = m_tdata[38:34];
                if (expected_cells.size() == 0) begin
                    report("result transaction with nothing expected");
                end else begin
                    want = expected_cells.pop_front();
                    if (got.write_enable !== want.write_enable)
                        report($sformatf("write_enable got %0d expected %0d",
                                         got.write_enable, want.write_enable));
                    if (got.cell_address !== want.cell_address)
                        report($sformatf("cell_address got %0d expected %0d",
                                         got.cell_address, want.cell_address));
                    if (got.cell_data !== want.cell_data)
                        report($sformatf("cell_data got %h expected %h",
                                         got.cell_data, want.cell_data));
                    if (got.column_now !== want.column_now)
                        report($sformatf("column_now got %0d expected %0d",
                                         got.column_now, want.column_now));
                    if (got.row_now !== want.row_now)
                        report($sformatf("row_now got %0d expected %0d",
                                         got.row_now, want.row_now));
                end
            end
            if (cfg_valid && cfg_ready) begin
                colour = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                req.op        = op_t'(s_tuser[0]);
                req.char_code = s_tdata[7:0];
                req.cursor_x  = s_tdata[14:8];
                req.cursor_y  = s_tdata[19:15];
                expected_cells.push_back(advance_cursor(req));
            end
            in_flight <= expected_cells.size();
        end
    end

endmodule

FILE: tb/text_terminal_cursor_writer_unit_tb.sv
// Testbench top for the text terminal cursor writer: clock, reset, stimulus and verdict.
module text_terminal_cursor_writer_unit_tb;
    import ttcw_pkg::*;

    localparam int TERM_W      = SCREEN_WIDTH_DEF;
    localparam int TERM_H      = SCREEN_HEIGHT_DEF;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 205;
    localparam int CYCLE_LIMIT = 200000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    int mismatch_count;
    int in_flight;
    int cycle_count = 0;
    int src_gap_max = 4;
    int snk_gap_max = 4;

    text_terminal_cursor_writer_unit #(
        .SCREEN_WIDTH (TERM_W),
        .SCREEN_HEIGHT(TERM_H)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    ttcw_result_checker #(
        .SCREEN_WIDTH (TERM_W),
        .SCREEN_HEIGHT(TERM_H)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatch_count(mismatch_count),
        .in_flight     (in_flight)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic item_t request(input op_t op, input logic [7:0] ch,
                                      input logic [6:0] x, input logic [4:0] y);
        item_t req;
        req.op        = op;
        req.char_code = ch;
        req.cursor_x  = x;
        req.cursor_y  = y;
        return req;
    endfunction

    function automatic item_t random_request();
        int          pick;
        logic [7:0]  ch;
        logic [6:0]  x;
        logic [4:0]  y;
        pick = $urandom_range(0, 99);
        ch   = 8'($urandom);
        x    = 7'($urandom);
        y    = 5'($urandom);
        if (pick < 8) begin
            return request(OP_SET, ch, x, y);   // often out of range
        end else if (pick < 16) begin
            case ($urandom_range(0, 2))
                0:       x = 7'd0;
                1:       x = 7'(TERM_W - 1);
                default: x = 7'($urandom_range(0, TERM_W - 1));
            endcase
            y = 5'($urandom_range(0, TERM_H - 1));
            return request(OP_SET, ch, x, y);
        end else if (pick < 24) begin
            return request(OP_PUT, CH_NEWLINE, x, y);
        end else if (pick < 32) begin
            return request(OP_PUT, CH_BACKSPACE, x, y);
        end else if (pick < 40) begin
            return request(OP_PUT, CH_TAB, x, y);
        end
        return request(OP_PUT, ch, x, y);
    endfunction

    // Holds s_tvalid across back-to-back transactions; drops it only for a gap.
    task automatic send_request(input item_t req);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, req.cursor_y, req.cursor_x, req.char_code};
        s_tuser  <= req.op;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_colour(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stall before each transaction.
    initial begin : result_sink
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = $urandom_range(0, snk_gap_max);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        logic [7:0] colour;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner cases under the reset colour
        send_request(request(OP_PUT, 8'h41, 7'h7F, 5'h1F));
        send_request(request(OP_PUT, 8'h00, 7'd0, 5'd0));
        send_request(request(OP_PUT, 8'hFF, 7'd0, 5'd0));
        send_request(request(OP_PUT, 8'h0D, 7'd0, 5'd0));
        send_request(request(OP_PUT, CH_TAB, 7'd0, 5'd0));
        send_request(request(OP_PUT, CH_NEWLINE, 7'd0, 5'd0));
        send_request(request(OP_PUT, CH_BACKSPACE, 7'd0, 5'd0));   // back across row
        send_request(request(OP_SET, 8'h00, 7'd0, 5'd0));
        send_request(request(OP_PUT, CH_BACKSPACE, 7'd0, 5'd0));   // pinned at top-left
        send_request(request(OP_SET, 8'h00, 7'(TERM_W - 1), 5'(TERM_H - 1)));
        send_request(request(OP_PUT, 8'h5A, 7'd0, 5'd0));          // wraps to origin
        send_request(request(OP_SET, 8'h00, 7'(TERM_W - 1), 5'(TERM_H - 1)));
        send_request(request(OP_PUT, CH_TAB, 7'd0, 5'd0));
        send_request(request(OP_SET, 8'h00, 7'd10, 5'(TERM_H - 1)));
        send_request(request(OP_PUT, CH_NEWLINE, 7'd0, 5'd0));
        send_request(request(OP_SET, 8'h00, 7'h7F, 5'h1F));        // ignored
        send_request(request(OP_SET, 8'h00, 7'(TERM_W), 5'd3));    // ignored
        send_request(request(OP_SET, 8'h00, 7'd3, 5'(TERM_H)));    // ignored
        send_request(request(OP_SET, 8'h00, 7'd72, 5'd5));
        send_request(request(OP_PUT, CH_TAB, 7'd0, 5'd0));
        send_request(request(OP_SET, 8'hFF, 7'd5, 5'd2));
        send_request(request(OP_PUT, CH_TAB, 7'd0, 5'd0));
        send_request(request(OP_PUT, CH_BACKSPACE, 7'd0, 5'd0));

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0:       colour = 8'h00;
                1:       colour = 8'hFF;
                default: colour = 8'($urandom);
            endcase
            write_colour(colour);
            case (phase % 4)
                2: begin
                    src_gap_max = 0;
                    snk_gap_max = 0;
                end
                3: begin
                    src_gap_max = 0;
                    snk_gap_max = 4;
                end
                default: begin
                    src_gap_max = 4;
                    snk_gap_max = 4;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request(random_request());
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
